/* rtl/core/gbmp_pkg.sv */
// gbmp_pkg: shared sizes, register codes and the dimension clamp of the grid mean pooling core
// used by grid_block_mean_pooling_core and gbmp_checker; depends on nothing

package gbmp_pkg;

   // block sizes
   localparam int GRID        = 4;
   localparam int MAX_DIM     = 4096;
   localparam int SAMPLE_BITS = 16;

   // fixed field widths
   localparam int DIM_BITS       = 13;
   localparam int IDX_BITS       = 2;
   localparam int CSR_INDEX_BITS = 1;

   // derived widths
   localparam int POS_BITS     = $clog2(MAX_DIM);
   localparam int STEP_BITS    = $clog2(MAX_DIM / GRID + 1);
   localparam int CELL_BITS    = $clog2(GRID + 1);
   localparam int SUM_BITS     = SAMPLE_BITS + 2 * $clog2(MAX_DIM / GRID);
   localparam int AREA_BITS    = 2 * STEP_BITS;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
   localparam int RS_CNT_BITS  = $clog2(POS_BITS + 1);

   // register reset values
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SUM_BITS-1:0]    sum_type;

   // saturate a map dimension to the range GRID .. MAX_DIM
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v < DIM_BITS'(GRID)) begin
         r = DIM_BITS'(GRID);
      end else if (v > DIM_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

/* rtl/core/grid_block_mean_pooling_core.sv */
// grid_block_mean_pooling_core: grid mean pooling over a raster pixel stream
// holds the column sum memory, the position tracking and the mean divider; uses gbmp_pkg
//
// Pixels enter one request at a time in raster order and are summed into one of GRID
// cell columns held in a small synchronous memory (read, add, write back, with
// forwarding between neighbouring requests). A stream of pixels that close no cell runs
// at one request per clock while no position rebuild holds the request side. A pixel that
// closes a cell passes through the read-modify-write stage, a bit-serial divider that
// forms the mean one quotient bit per cycle, and the hand-over of the mean to the output
// register before the next request is taken. The hand-over waits while an earlier result
// is still held there by a stalled receiver. Once handed over, the mean waits in the
// output register while new requests flow in. After each csr write the cell position is
// rebuilt from the pixel position by two bit-serial dividers, which hold the request side
// until they finish. Image dimensions are clamped to GRID .. MAX_DIM; remainder rows and
// columns add to no cell. Write the csr registers only while the block is idle.

module grid_block_mean_pooling_core (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [gbmp_pkg::SAMPLE_BITS-1:0]  req_sample,
   input  logic                                     req_start_of_map,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [gbmp_pkg::SAMPLE_BITS-1:0]  rsp_cell_mean,
   output logic [gbmp_pkg::IDX_BITS-1:0]            rsp_cell_row,
   output logic [gbmp_pkg::IDX_BITS-1:0]            rsp_cell_col,
   output logic                                     rsp_last_of_map,
   // csr write port
   input  logic                                     csr_write_enable,
   input  logic [gbmp_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [gbmp_pkg::DIM_BITS-1:0]            csr_write_data
);

   localparam int SB  = gbmp_pkg::SAMPLE_BITS;
   localparam int SUB = gbmp_pkg::SUM_BITS;
   localparam int PB  = gbmp_pkg::POS_BITS;
   localparam int STB = gbmp_pkg::STEP_BITS;
   localparam int CB  = gbmp_pkg::CELL_BITS;
   localparam int IB  = gbmp_pkg::IDX_BITS;
   localparam int DB  = gbmp_pkg::DIM_BITS;
   localparam int AB  = gbmp_pkg::AREA_BITS;

   // request in the read-modify-write stage
   typedef struct packed {
      gbmp_pkg::sample_type sample;
      logic [IB-1:0]        idx;
      logic                 add;
      logic                 emit;
      logic                 use_zero;
      logic                 fwd;
      logic [IB-1:0]        row;
      logic                 last;
   } s1_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // csr registers
   logic [DB-1:0] width_ff;
   logic [DB-1:0] height_ff;

   // pixel and cell position
   logic [PB-1:0]        col_pos_ff;
   logic [PB-1:0]        row_pos_ff;
   logic [STB-1:0]       col_off_ff;
   logic [STB-1:0]       row_off_ff;
   logic [CB-1:0]        cx_ff;
   logic [CB-1:0]        cy_ff;
   logic [gbmp_pkg::GRID-1:0] valid_ff;

   // column sum memory and forwarding
   gbmp_pkg::sum_type sum_mem [gbmp_pkg::GRID];
   gbmp_pkg::sum_type mem_q_ff;
   gbmp_pkg::sum_type fwd_sum_ff;
   s1_type            s1_ff;
   logic              s1_valid_ff;

   // position rebuild after a csr write
   logic [gbmp_pkg::RS_CNT_BITS-1:0] rs_cnt_ff;
   logic [PB-1:0]                    rs_col_q_ff;
   logic [PB-1:0]                    rs_row_q_ff;
   logic [STB-1:0]                   rs_col_rem_ff;
   logic [STB-1:0]                   rs_row_rem_ff;

   // mean divider and output register
   div_state_type                     div_state_ff;
   logic [gbmp_pkg::DIV_CNT_BITS-1:0] div_cnt_ff;
   gbmp_pkg::sum_type                 div_q_ff;
   logic [AB-1:0]                     div_rem_ff;
   logic [AB-1:0]                     divisor_ff;
   logic                              div_neg_ff;
   logic [IB-1:0]                     div_row_ff;
   logic [IB-1:0]                     div_col_ff;
   logic                              div_last_ff;
   logic                              rsp_valid_ff;
   gbmp_pkg::sample_type              rsp_mean_ff;
   logic [IB-1:0]                     rsp_row_ff;
   logic [IB-1:0]                     rsp_col_ff;
   logic                              rsp_last_ff;

   // cell geometry
   logic [DB-1:0]  w_cl;
   logic [DB-1:0]  h_cl;
   logic [STB-1:0] step_w;
   logic [STB-1:0] step_h;
   logic [STB-1:0] step_w_m1;
   logic [STB-1:0] step_h_m1;

   assign w_cl      = gbmp_pkg::clamp_dim(width_ff);
   assign h_cl      = gbmp_pkg::clamp_dim(height_ff);
   assign step_w    = STB'(w_cl / gbmp_pkg::GRID);
   assign step_h    = STB'(h_cl / gbmp_pkg::GRID);
   assign step_w_m1 = step_w - STB'(1);
   assign step_h_m1 = step_h - STB'(1);

   // handshake
   logic rs_busy;
   logic req_accept;

   assign rs_busy    = (rs_cnt_ff != '0);
   assign req_stall  = rs_busy || (div_state_ff != DIV_IDLE) || (s1_valid_ff && s1_ff.emit);
   assign req_accept = req_valid && !req_stall && !reset;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gbmp_pkg::WIDTH_RESET;
         height_ff <= gbmp_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gbmp_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            gbmp_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
         endcase
      end
   end

   // position rebuild: col_pos / step_w and row_pos / step_h, one bit a cycle
   logic [STB:0]   rs_col_trial;
   logic [STB:0]   rs_row_trial;
   logic [STB:0]   rs_col_diff;
   logic [STB:0]   rs_row_diff;
   logic           rs_col_ge;
   logic           rs_row_ge;
   logic [STB-1:0] rs_col_rem_in;
   logic [STB-1:0] rs_row_rem_in;
   logic [PB-1:0]  rs_col_q_in;
   logic [PB-1:0]  rs_row_q_in;
   logic           rs_done;
   logic [CB-1:0]  rs_cx;
   logic [CB-1:0]  rs_cy;

   always_comb begin
      rs_col_trial  = {rs_col_rem_ff, rs_col_q_ff[PB-1]};
      rs_row_trial  = {rs_row_rem_ff, rs_row_q_ff[PB-1]};
      rs_col_diff   = rs_col_trial - {1'b0, step_w};
      rs_row_diff   = rs_row_trial - {1'b0, step_h};
      rs_col_ge     = (rs_col_trial >= {1'b0, step_w});
      rs_row_ge     = (rs_row_trial >= {1'b0, step_h});
      rs_col_rem_in = rs_col_ge ? rs_col_diff[STB-1:0] : rs_col_trial[STB-1:0];
      rs_row_rem_in = rs_row_ge ? rs_row_diff[STB-1:0] : rs_row_trial[STB-1:0];
      rs_col_q_in   = {rs_col_q_ff[PB-2:0], rs_col_ge};
      rs_row_q_in   = {rs_row_q_ff[PB-2:0], rs_row_ge};
      rs_done       = (rs_cnt_ff == gbmp_pkg::RS_CNT_BITS'(1));
      // a cell index past the grid saturates at GRID
      rs_cx = (rs_col_q_in >= PB'(gbmp_pkg::GRID)) ? CB'(gbmp_pkg::GRID) : rs_col_q_in[CB-1:0];
      rs_cy = (rs_row_q_in >= PB'(gbmp_pkg::GRID)) ? CB'(gbmp_pkg::GRID) : rs_row_q_in[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_cnt_ff <= '0;
      end else if (csr_write_enable) begin
         rs_cnt_ff     <= gbmp_pkg::RS_CNT_BITS'(PB);
         rs_col_q_ff   <= col_pos_ff;
         rs_row_q_ff   <= row_pos_ff;
         rs_col_rem_ff <= '0;
         rs_row_rem_ff <= '0;
      end else if (rs_busy) begin
         rs_cnt_ff     <= rs_cnt_ff - gbmp_pkg::RS_CNT_BITS'(1);
         rs_col_q_ff   <= rs_col_q_in;
         rs_row_q_ff   <= rs_row_q_in;
         rs_col_rem_ff <= rs_col_rem_in;
         rs_row_rem_ff <= rs_row_rem_in;
      end
   end

   // request stage: position of this pixel, cell decision, position advance
   logic [PB-1:0]             cur_col;
   logic [PB-1:0]             cur_row;
   logic [STB-1:0]            cur_col_off;
   logic [STB-1:0]            cur_row_off;
   logic [CB-1:0]             cur_cx;
   logic [CB-1:0]             cur_cy;
   logic [gbmp_pkg::GRID-1:0] v_base;
   logic                      in_grid;
   logic                      emit;
   logic [IB-1:0]             idx;
   logic                      col_wrap;
   logic                      row_wrap;
   logic [PB-1:0]             col_pos_in;
   logic [PB-1:0]             row_pos_in;
   logic [STB-1:0]            col_off_in;
   logic [STB-1:0]            row_off_in;
   logic [CB-1:0]             cx_in;
   logic [CB-1:0]             cy_in;
   logic [gbmp_pkg::GRID-1:0] valid_in;
   s1_type                    s1_in;

   always_comb begin
      // start flag puts this pixel at the origin with all sums clear
      cur_col     = req_start_of_map ? '0 : col_pos_ff;
      cur_row     = req_start_of_map ? '0 : row_pos_ff;
      cur_col_off = req_start_of_map ? '0 : col_off_ff;
      cur_row_off = req_start_of_map ? '0 : row_off_ff;
      cur_cx      = req_start_of_map ? '0 : cx_ff;
      cur_cy      = req_start_of_map ? '0 : cy_ff;
      v_base      = req_start_of_map ? '0 : valid_ff;

      in_grid  = (cur_cx < CB'(gbmp_pkg::GRID)) && (cur_cy < CB'(gbmp_pkg::GRID));
      emit     = in_grid && (cur_col_off == step_w_m1) && (cur_row_off == step_h_m1);
      idx      = cur_cx[IB-1:0];
      col_wrap = (DB'(cur_col) + DB'(1) >= w_cl);
      row_wrap = (DB'(cur_row) + DB'(1) >= h_cl);

      col_pos_in = cur_col;
      row_pos_in = cur_row;
      col_off_in = cur_col_off;
      row_off_in = cur_row_off;
      cx_in      = cur_cx;
      cy_in      = cur_cy;
      if (col_wrap) begin
         col_pos_in = '0;
         col_off_in = '0;
         cx_in      = '0;
         if (row_wrap) begin
            row_pos_in = '0;
            row_off_in = '0;
            cy_in      = '0;
         end else begin
            row_pos_in = cur_row + PB'(1);
            if (cur_row_off == step_h_m1) begin
               row_off_in = '0;
               cy_in = (cur_cy == CB'(gbmp_pkg::GRID)) ? cur_cy : cur_cy + CB'(1);
            end else begin
               row_off_in = cur_row_off + STB'(1);
            end
         end
      end else begin
         col_pos_in = cur_col + PB'(1);
         if (cur_col_off == step_w_m1) begin
            col_off_in = '0;
            cx_in = (cur_cx == CB'(gbmp_pkg::GRID)) ? cur_cx : cur_cx + CB'(1);
         end else begin
            col_off_in = cur_col_off + STB'(1);
         end
      end

      // an entry holds a live sum only between its first pixel and its cell close
      valid_in = v_base;
      if (in_grid) begin
         valid_in[idx] = !emit;
      end
      if (col_wrap && row_wrap) begin
         valid_in = '0;
      end

      s1_in.sample   = req_sample;
      s1_in.idx      = idx;
      s1_in.add      = in_grid;
      s1_in.emit     = emit;
      s1_in.use_zero = !v_base[idx];
      s1_in.fwd      = s1_valid_ff && s1_ff.add && (s1_ff.idx == idx);
      s1_in.row      = cur_cy[IB-1:0];
      s1_in.last     = (cur_cx == CB'(gbmp_pkg::GRID - 1)) && (cur_cy == CB'(gbmp_pkg::GRID - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         col_off_ff <= '0;
         row_off_ff <= '0;
         cx_ff      <= '0;
         cy_ff      <= '0;
         valid_ff   <= '0;
      end else if (rs_done) begin
         col_off_ff <= rs_col_rem_in;
         row_off_ff <= rs_row_rem_in;
         cx_ff      <= rs_cx;
         cy_ff      <= rs_cy;
      end else if (req_accept) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         col_off_ff <= col_off_in;
         row_off_ff <= row_off_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         valid_ff   <= valid_in;
      end
   end

   // read-modify-write stage
   gbmp_pkg::sum_type s1_old;
   gbmp_pkg::sum_type s1_sum;

   always_comb begin
      priority if (s1_ff.use_zero) begin
         s1_old = '0;
      end else if (s1_ff.fwd) begin
         s1_old = fwd_sum_ff;
      end else begin
         s1_old = mem_q_ff;
      end
      s1_sum = s1_old + {{(SUB - SB){s1_ff.sample[SB-1]}}, s1_ff.sample};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff    <= s1_in;
         mem_q_ff <= sum_mem[idx];
      end
      // sum of the request leaving the stage, for a follower on the same column
      fwd_sum_ff <= s1_sum;
      if (s1_valid_ff && s1_ff.add) begin
         sum_mem[s1_ff.idx] <= s1_sum;
      end
   end

   // mean divider: magnitude restoring division, one quotient bit a cycle
   logic [AB:0]       div_trial;
   logic [AB:0]       div_diff;
   logic              div_ge;
   logic              div_launch;
   gbmp_pkg::sum_type div_mag;
   gbmp_pkg::sum_type div_signed_q;
   logic              rsp_free;

   always_comb begin
      div_trial    = {div_rem_ff, div_q_ff[SUB-1]};
      div_diff     = div_trial - {1'b0, divisor_ff};
      div_ge       = (div_trial >= {1'b0, divisor_ff});
      div_launch   = s1_valid_ff && s1_ff.emit;
      div_mag      = s1_sum[SUB-1] ? (~s1_sum + SUB'(1)) : s1_sum;
      div_signed_q = div_neg_ff ? (~div_q_ff + SUB'(1)) : div_q_ff;
      rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff <= DIV_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a taken result leaves unless the divider hands over the next one
         if (rsp_valid_ff && !rsp_stall && (div_state_ff != DIV_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (div_state_ff)
            DIV_IDLE: begin
               if (div_launch) begin
                  div_q_ff     <= div_mag;
                  div_neg_ff   <= s1_sum[SUB-1];
                  div_rem_ff   <= '0;
                  divisor_ff   <= AB'(step_w) * AB'(step_h);
                  div_cnt_ff   <= gbmp_pkg::DIV_CNT_BITS'(SUB);
                  div_row_ff   <= s1_ff.row;
                  div_col_ff   <= s1_ff.idx;
                  div_last_ff  <= s1_ff.last;
                  div_state_ff <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               div_q_ff   <= {div_q_ff[SUB-2:0], div_ge};
               div_rem_ff <= div_ge ? div_diff[AB-1:0] : div_trial[AB-1:0];
               div_cnt_ff <= div_cnt_ff - gbmp_pkg::DIV_CNT_BITS'(1);
               if (div_cnt_ff == gbmp_pkg::DIV_CNT_BITS'(1)) begin
                  div_state_ff <= DIV_DONE;
               end
            end
            DIV_DONE: begin
               // hand over once the output register is free or being taken
               if (rsp_free) begin
                  rsp_mean_ff  <= div_signed_q[SB-1:0];
                  rsp_row_ff   <= div_row_ff;
                  rsp_col_ff   <= div_col_ff;
                  rsp_last_ff  <= div_last_ff;
                  rsp_valid_ff <= 1'b1;
                  div_state_ff <= DIV_IDLE;
               end
            end
            default: begin
               div_state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_mean   = rsp_mean_ff;
   assign rsp_cell_row    = rsp_row_ff;
   assign rsp_cell_col    = rsp_col_ff;
   assign rsp_last_of_map = rsp_last_ff;

endmodule

/* rtl/core/gbmp_checker.sv */
// gbmp_checker: port-level assertions for grid_block_mean_pooling_core, bound into that module
// uses gbmp_pkg for field widths

module gbmp_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [gbmp_pkg::SAMPLE_BITS-1:0] rsp_cell_mean,
   input logic [gbmp_pkg::IDX_BITS-1:0]           rsp_cell_row,
   input logic [gbmp_pkg::IDX_BITS-1:0]           rsp_cell_col,
   input logic                                    rsp_last_of_map,
   input logic                                    csr_write_enable
);

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cell_mean) && $stable(rsp_cell_row)
         && $stable(rsp_cell_col) && $stable(rsp_last_of_map))
      else $error("stalled result payload changed");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a csr write starts the position rebuild, which holds off requests
   a_csr_stall: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("request side open right after csr write");

   // a new result comes from the divider, which holds off requests while it runs
   a_rsp_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without divider activity");

endmodule

bind grid_block_mean_pooling_core gbmp_checker u_gbmp_checker (.*);
